### src/coso_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// coso_pkg
// shared types, constants and the cordic arctangent table
// ---------------------------------------------------------------------------
package coso_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int DW           = 45;   // cordic x/y datapath width

   localparam logic [DW-1:0] CORDIC_GAIN_Q30 = DW'(652032874);
   localparam logic [28:0]   NEAR_LIMIT_Q32  = 29'd42949673;
   localparam logic [32:0]   NEAR_COMP_Q16   = 33'd6554;

   // register indexes
   localparam logic [2:0] REG_RADIUS   = 3'd0;
   localparam logic [2:0] REG_RATE     = 3'd1;
   localparam logic [2:0] REG_CENTER_X = 3'd2;
   localparam logic [2:0] REG_CENTER_Y = 3'd3;
   localparam logic [2:0] REG_CENTER_Z = 3'd4;
   localparam logic [2:0] REG_TARGET_X = 3'd5;
   localparam logic [2:0] REG_TARGET_Y = 3'd6;

   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   typedef struct packed {
      logic                 valid;
      logic                 vec;     // 1 = vectoring (atan2), 0 = rotation
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic [31:0]          z;
   } cordic_beat_type;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_PHASE, S_ROT, S_ROT_WAIT, S_SCALE, S_ROUND, S_POS,
      S_DIFF, S_NEAR, S_NORM, S_VEC, S_VEC_WAIT, S_EMIT
   } state_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] a;
      case (i)
         5'd0:  a = 32'd536870912;
         5'd1:  a = 32'd316933406;
         5'd2:  a = 32'd167458907;
         5'd3:  a = 32'd85004756;
         5'd4:  a = 32'd42667331;
         5'd5:  a = 32'd21354465;
         5'd6:  a = 32'd10679838;
         5'd7:  a = 32'd5340245;
         5'd8:  a = 32'd2670163;
         5'd9:  a = 32'd1335087;
         5'd10: a = 32'd667544;
         5'd11: a = 32'd333772;
         5'd12: a = 32'd166886;
         5'd13: a = 32'd83443;
         5'd14: a = 32'd41722;
         5'd15: a = 32'd20861;
         5'd16: a = 32'd10430;
         5'd17: a = 32'd5215;
         5'd18: a = 32'd2608;
         5'd19: a = 32'd1304;
         5'd20: a = 32'd652;
         5'd21: a = 32'd326;
         5'd22: a = 32'd163;
         5'd23: a = 32'd81;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

endpackage

### src/circle_orbit_setpoint_generator_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// circle_orbit_setpoint_generator_unit
// orbit setpoint generator: phase accumulator, cordic sin/cos and atan2
// ---------------------------------------------------------------------------
// usage:
//   req_ channel takes one beat per command: a tick (advance the phase by
//   phase_rate * elapsed_us and produce one setpoint) or a restart (clear
//   the phase, no response). rsp_ channel returns position and heading.
//   csr_ port writes the seven configuration registers; the user must do so while idle (not enforced).
// sequence:
//   a restart is handled in idle and returns no beat. a tick runs the
//   multiply, the phase update, a rotation pass through the cordic cell
//   row, scaling, rounding, position, target difference and the near
//   test; then, unless the target is too close, the prescale loop and a
//   vectoring pass through the row for the heading. one tick is in flight
//   at a time, so the next tick is taken only once the last one is emitted.
// reset:
//   synchronous, clears phase, configuration registers, response valid and control.
// stalls:
//   the result sits in an output register; the next tick is accepted and
//   computed while it waits, and is held at the end until it is taken.
// ---------------------------------------------------------------------------
module circle_orbit_setpoint_generator_unit
   import coso_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [19:0]        req_elapsed_us,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pos_north,
   output logic signed [31:0] rsp_pos_east,
   output logic signed [31:0] rsp_pos_down,
   output logic signed [15:0] rsp_heading,
   output logic               rsp_heading_valid,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   state_type state_ff, state_in;

   logic [30:0] radius_ff;
   logic [31:0] rate_ff, cx_ff, cy_ff, cz_ff, tx_ff, ty_ff;
   logic [31:0] phase_ff;

   logic [19:0]          dt_ff;
   logic [31:0]          prod_ff;
   logic                 flip_ff;
   logic signed [32:0]   c_ff, s_ff;
   logic signed [64:0]   pc_ff, ps_ff;
   logic [31:0]          rc_ff, rs_ff;
   logic [31:0]          north_ff, east_ff;
   logic signed [DW-1:0] vx_ff, vy_ff;
   logic                 hvalid_ff;
   logic [15:0]          heading_ff;

   logic               rsp_valid_ff;
   logic [31:0]        out_n_ff, out_e_ff, out_d_ff;
   logic [15:0]        out_h_ff;
   logic               out_hv_ff;

   cordic_beat_type chain_in, chain_out;

   logic                 accept, load_out;
   logic signed [DW-1:0] c_full, s_full;
   logic [DW-1:0]        magx, magy;
   logic                 lt32, lt40;
   logic [32:0]          adx, ady;
   logic signed [13:0]   dxs, dys;
   logic [28:0]          sq_sum;
   logic [31:0]          phase_flip;
   logic [31:0]          z_round;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign load_out  = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);

   coso_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .chain_in  (chain_in),
      .chain_out (chain_out)
   );

   // datapath helpers
   always_comb begin
      phase_flip = phase_ff + 32'h4000_0000;
      c_full     = flip_ff ? -chain_out.x : chain_out.x;
      s_full     = flip_ff ? -chain_out.y : chain_out.y;
      magx       = vx_ff[DW-1] ? DW'(-vx_ff) : DW'(vx_ff);
      magy       = vy_ff[DW-1] ? DW'(-vy_ff) : DW'(vy_ff);
      lt32       = (magx < (DW'(1) << 32)) && (magy < (DW'(1) << 32));
      lt40       = (magx < (DW'(1) << 40)) && (magy < (DW'(1) << 40));
      adx        = vx_ff[32] ? 33'(-vx_ff[32:0]) : vx_ff[32:0];
      ady        = vy_ff[32] ? 33'(-vy_ff[32:0]) : vy_ff[32:0];
      dxs        = vx_ff[13:0];
      dys        = vy_ff[13:0];
      sq_sum     = 29'(28'(dxs * dxs)) + 29'(28'(dys * dys));
      z_round    = chain_out.z + 32'h0000_8000;

      chain_in       = '0;
      chain_in.valid = (state_ff == S_ROT) || (state_ff == S_VEC);
      if (state_ff == S_VEC) begin
         chain_in.vec = 1'b1;
         chain_in.x   = vx_ff[DW-1] ? -vx_ff : vx_ff;
         chain_in.y   = vx_ff[DW-1] ? -vy_ff : vy_ff;
         chain_in.z   = vx_ff[DW-1] ? 32'h8000_0000 : 32'h0;
      end else begin
         chain_in.vec = 1'b0;
         chain_in.x   = CORDIC_GAIN_Q30;
         chain_in.y   = '0;
         chain_in.z   = phase_flip[31] ? (phase_ff + 32'h8000_0000) : phase_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_opcode == OP_TICK) state_in = S_MUL;
         end
         S_MUL:      state_in = S_PHASE;
         S_PHASE:    state_in = S_ROT;
         S_ROT:      state_in = S_ROT_WAIT;
         S_ROT_WAIT: if (chain_out.valid) state_in = S_SCALE;
         S_SCALE:    state_in = S_ROUND;
         S_ROUND:    state_in = S_POS;
         S_POS:      state_in = S_DIFF;
         S_DIFF:     state_in = S_NEAR;
         S_NEAR: begin
            if ((adx >= NEAR_COMP_Q16) || (ady >= NEAR_COMP_Q16) ||
                (sq_sum >= NEAR_LIMIT_Q32)) begin
               state_in = S_NORM;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_NORM:     if (!lt40) state_in = S_VEC;
         S_VEC:      state_in = S_VEC_WAIT;
         S_VEC_WAIT: if (chain_out.valid) state_in = S_EMIT;
         S_EMIT:     if (load_out) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration and phase
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
         rate_ff   <= '0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         cz_ff     <= '0;
         tx_ff     <= '0;
         ty_ff     <= '0;
         phase_ff  <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_RADIUS:   radius_ff <= csr_wdata[30:0];
               REG_RATE:     rate_ff   <= csr_wdata;
               REG_CENTER_X: cx_ff     <= csr_wdata;
               REG_CENTER_Y: cy_ff     <= csr_wdata;
               REG_CENTER_Z: cz_ff     <= csr_wdata;
               REG_TARGET_X: tx_ff     <= csr_wdata;
               REG_TARGET_Y: ty_ff     <= csr_wdata;
               default: ;
            endcase
         end
         if (accept && req_opcode == OP_RESTART) begin
            phase_ff <= '0;
         end else if (state_ff == S_PHASE) begin
            phase_ff <= phase_ff + prod_ff;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE:  dt_ff   <= req_elapsed_us;
         S_MUL:   prod_ff <= 32'(rate_ff * {12'd0, dt_ff});
         S_ROT:   flip_ff <= phase_flip[31];
         S_ROT_WAIT: begin
            c_ff <= c_full[32:0];
            s_ff <= s_full[32:0];
         end
         S_SCALE: begin
            pc_ff <= $signed({1'b0, radius_ff}) * c_ff;
            ps_ff <= $signed({1'b0, radius_ff}) * s_ff;
         end
         S_ROUND: begin
            rc_ff <= 32'((pc_ff + 65'sd536870912) >>> 30);
            rs_ff <= 32'((ps_ff + 65'sd536870912) >>> 30);
         end
         S_POS: begin
            north_ff <= cx_ff + rc_ff;
            east_ff  <= cy_ff + rs_ff;
         end
         S_DIFF: begin
            vx_ff <= DW'($signed({tx_ff[31], tx_ff}) - $signed({north_ff[31], north_ff}));
            vy_ff <= DW'($signed({ty_ff[31], ty_ff}) - $signed({east_ff[31], east_ff}));
         end
         S_NEAR: begin
            hvalid_ff  <= (adx >= NEAR_COMP_Q16) || (ady >= NEAR_COMP_Q16) ||
                          (sq_sum >= NEAR_LIMIT_Q32);
            heading_ff <= '0;
         end
         S_NORM: begin
            // coarse steps while far below the target magnitude
            if (lt32) begin
               vx_ff <= vx_ff <<< 8;
               vy_ff <= vy_ff <<< 8;
            end else if (lt40) begin
               vx_ff <= vx_ff <<< 1;
               vy_ff <= vy_ff <<< 1;
            end
         end
         S_VEC_WAIT: heading_ff <= z_round[31:16];
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_out) begin
         out_n_ff  <= north_ff;
         out_e_ff  <= east_ff;
         out_d_ff  <= cz_ff;
         out_h_ff  <= heading_ff;
         out_hv_ff <= hvalid_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pos_north     = out_n_ff;
   assign rsp_pos_east      = out_e_ff;
   assign rsp_pos_down      = out_d_ff;
   assign rsp_heading       = out_h_ff;
   assign rsp_heading_valid = out_hv_ff;

endmodule

### src/coso_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// coso_cell
// one registered cordic micro-rotation, rotation or vectoring mode
// ---------------------------------------------------------------------------
module coso_cell
   import coso_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [4:0]      shift,
   input  logic [31:0]     angle,
   input  cordic_beat_type beat_in,
   output cordic_beat_type beat_out
);

   cordic_beat_type      beat_ff, beat_in_d;
   logic signed [DW-1:0] xs, ys;
   logic                 d;

   always_comb begin
      xs = beat_in.x >>> shift;
      ys = beat_in.y >>> shift;
      // rotate clockwise when angle left is negative / y is non-negative
      d  = beat_in.vec ? ~beat_in.y[DW-1] : beat_in.z[31];
      beat_in_d       = beat_in;
      if (d) begin
         beat_in_d.x = beat_in.x + ys;
         beat_in_d.y = beat_in.y - xs;
         beat_in_d.z = beat_in.z + angle;
      end else begin
         beat_in_d.x = beat_in.x - ys;
         beat_in_d.y = beat_in.y + xs;
         beat_in_d.z = beat_in.z - angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff.valid <= beat_in.valid;
      end
      beat_ff.vec <= beat_in_d.vec;
      beat_ff.x   <= beat_in_d.x;
      beat_ff.y   <= beat_in_d.y;
      beat_ff.z   <= beat_in_d.z;
   end

   assign beat_out = beat_ff;

endmodule

### src/coso_chain.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// coso_chain
// row of cordic cells, one registered iteration per cell
// ---------------------------------------------------------------------------
module coso_chain
   import coso_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cordic_beat_type chain_in,
   output cordic_beat_type chain_out
);

   cordic_beat_type link [CORDIC_STEPS+1];

   assign link[0] = chain_in;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      coso_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (5'(i)),
         .angle    (atan_entry(5'(i))),
         .beat_in  (link[i]),
         .beat_out (link[i+1])
      );
   end

   assign chain_out = link[CORDIC_STEPS];

endmodule

### src/coso_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// coso_checker
// port-level checks for the orbit setpoint generator
// ---------------------------------------------------------------------------
module coso_checker
   import coso_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_opcode,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_pos_north,
   input logic signed [15:0] rsp_heading,
   input logic               rsp_heading_valid
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_north))
      else $error("response beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_heading_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_heading_valid |-> rsp_heading == 16'sd0)
      else $error("heading not zero when marked invalid");

   // a tick keeps the block busy for the following cycle
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == OP_TICK |=> !req_ready)
      else $error("new beat taken right after a tick");

endmodule

bind circle_orbit_setpoint_generator_unit coso_checker u_coso_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_opcode        (req_opcode),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_pos_north     (rsp_pos_north),
   .rsp_heading       (rsp_heading),
   .rsp_heading_valid (rsp_heading_valid)
);

### sim/tb_circle_orbit_setpoint_generator_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_circle_orbit_setpoint_generator_unit
// self-checking bench for the orbit setpoint generator: a directed table
// with a few fixed answers, directed extreme orbits, then random ticks and
// restarts in changing orbits, checked against a cycle-free orbit predictor
// ---------------------------------------------------------------------------
module tb_circle_orbit_setpoint_generator_unit
   import coso_pkg::*;
();

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int SETTLE_CYCLES = 80;

   typedef struct {
      logic [31:0] north;
      logic [31:0] east;
      logic [31:0] down;
      logic [15:0] heading;
      logic        heading_valid;
   } setpoint_type;

   typedef struct {
      logic         op;
      logic [19:0]  dt;
      bit           typed;
      setpoint_type sp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_opcode = OP_TICK;
   logic [19:0] req_elapsed_us = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_pos_north, rsp_pos_east, rsp_pos_down;
   logic signed [15:0] rsp_heading;
   logic rsp_heading_valid;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // predictor copy of the registers and the phase
   logic [30:0] m_radius;
   logic [31:0] m_rate, m_cx, m_cy, m_cz, m_tx, m_ty, m_phase;

   setpoint_type setpoints_due[$];
   int  tx_idle_pct = 0;
   int  rx_idle_pct = 0;
   bit  hold_req = 0;
   int  errors = 0;

   circle_orbit_setpoint_generator_unit u_top (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("[circle_orbit_setpoint_generator_unit] ERROR");
      $finish;
   end

   function automatic void orbit_sincos(input logic [31:0] ang, output longint c,
                                        output longint s);
      longint x, y, t;
      logic [31:0] z, probe;
      bit flip;
      x = 64'sd652032874;
      y = 0;
      z = ang;
      probe = z + 32'h4000_0000;
      flip = probe[31];
      if (flip) z = z + 32'h8000_0000;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z[31]) begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z = z + atan_entry(5'(i));
         end else begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z = z - atan_entry(5'(i));
         end
         x = t;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic logic [31:0] bearing_turns(input longint dy, input longint dx);
      longint x, y, t;
      logic [31:0] z;
      x = dx;
      y = dy;
      z = 0;
      while ((x < 0 ? -x : x) < (64'sd1 <<< 40) && (y < 0 ? -y : y) < (64'sd1 <<< 40)) begin
         x = x * 2;
         y = y * 2;
      end
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (y < 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z = z - atan_entry(5'(i));
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z = z + atan_entry(5'(i));
         end
         x = t;
      end
      return z;
   endfunction

   // advance the orbit and return the setpoint, if a tick
   function automatic bit orbit_advance(input logic op, input logic [19:0] dt,
                                        output setpoint_type sp);
      longint c, s, r, pn, pe, dx, dy;
      logic [63:0] prod;
      logic [31:0] z, hz;
      bit near;
      if (op == OP_RESTART) begin
         m_phase = '0;
         return 0;
      end
      prod = {32'd0, m_rate} * {44'd0, dt};
      m_phase = m_phase + prod[31:0];
      orbit_sincos(m_phase, c, s);
      r = longint'({33'd0, m_radius});
      pn = longint'(signed'(m_cx)) + ((r * c + (64'sd1 <<< 29)) >>> 30);
      pe = longint'(signed'(m_cy)) + ((r * s + (64'sd1 <<< 29)) >>> 30);
      sp.north = pn[31:0];
      sp.east = pe[31:0];
      sp.down = m_cz;
      dx = longint'(signed'(m_tx)) - longint'(signed'(sp.north));
      dy = longint'(signed'(m_ty)) - longint'(signed'(sp.east));
      if ((dx < 0 ? -dx : dx) >= 6554 || (dy < 0 ? -dy : dy) >= 6554) near = 0;
      else near = (dx * dx + dy * dy) < 64'sd42949673;
      if (near) begin
         sp.heading = '0;
         sp.heading_valid = 1'b0;
      end else begin
         z = bearing_turns(dy, dx);
         hz = (z + 32'h8000) >> 16;
         sp.heading = hz[15:0];
         sp.heading_valid = 1'b1;
      end
      return 1;
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_RADIUS:   m_radius = val[30:0];
         REG_RATE:     m_rate = val;
         REG_CENTER_X: m_cx = val;
         REG_CENTER_Y: m_cy = val;
         REG_CENTER_Z: m_cz = val;
         REG_TARGET_X: m_tx = val;
         REG_TARGET_Y: m_ty = val;
         default: ;
      endcase
   endtask

   task automatic drain;
      // stop offering the last beat so it is not taken again
      req_valid <= 1'b0;
      while (setpoints_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_orbit(input logic [31:0] rad, rate, cx, cy, cz, tx, ty);
      drain();
      csr_write(REG_RADIUS, rad);
      csr_write(REG_RATE, rate);
      csr_write(REG_CENTER_X, cx);
      csr_write(REG_CENTER_Y, cy);
      csr_write(REG_CENTER_Z, cz);
      csr_write(REG_TARGET_X, tx);
      csr_write(REG_TARGET_Y, ty);
      csr_write(REG_UNUSED, $urandom);
   endtask

   // random orbit: mostly sane, some with the target near the path, some extreme
   task automatic load_random_orbit;
      logic [31:0] rad, cx, cy, tx, ty;
      int pick;
      pick = $urandom_range(9);
      cx = $urandom;
      cy = $urandom;
      if (pick < 3) begin
         rad = $urandom_range(3000);
         tx = cx + $urandom_range(12000) - 6000;
         ty = cy + $urandom_range(12000) - 6000;
      end else if (pick < 8) begin
         rad = $urandom_range(32'h00FF_FFFF);
         cx = cx >>> 8;
         cy = cy >>> 8;
         tx = $urandom >>> $urandom_range(12, 1);
         ty = $urandom >>> $urandom_range(12, 1);
      end else begin
         rad = $urandom_range(1) ? 32'h7FFF_FFFF : $urandom;
         tx = $urandom;
         ty = $urandom;
      end
      load_orbit(rad, $urandom, cx, cy, $urandom, tx, ty);
   endtask

   task automatic send_beat(input logic op, input logic [19:0] dt);
      setpoint_type sp;
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_elapsed_us <= dt;
      do @(posedge clock); while (!req_ready);
      if (orbit_advance(op, dt, sp)) setpoints_due.push_back(sp);
   endtask

   task automatic random_beats(input int n);
      logic [19:0] dt;
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(7))
            0: dt = $urandom_range(1000000);
            1: dt = $urandom_range(1) ? 20'd1000000 : 20'd0;
            default: dt = $urandom_range(20000);
         endcase
         send_beat(($urandom_range(9) == 0) ? OP_RESTART : OP_TICK, dt);
      end
   endtask

   // receiver: random stalls plus one long hold-off
   always @(posedge clock) begin : rx_side
      static int hold_cnt = 0;
      static bit hold_done = 0;
      if (hold_req && !hold_done) begin
         hold_done = 1;
         hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      setpoint_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (setpoints_due.size() == 0) begin
            $display("%0t unexpected setpoint beat north=%h", $realtime, rsp_pos_north);
            errors++;
         end else begin
            e = setpoints_due.pop_front();
            if (rsp_pos_north !== e.north || rsp_pos_east !== e.east ||
                rsp_pos_down !== e.down || rsp_heading !== e.heading ||
                rsp_heading_valid !== e.heading_valid) begin
               $display("%0t mismatch exp n=%h e=%h d=%h h=%h v=%b", $realtime,
                        e.north, e.east, e.down, e.heading, e.heading_valid);
               $display("%0t          got n=%h e=%h d=%h h=%h v=%b", $realtime,
                        rsp_pos_north, rsp_pos_east, rsp_pos_down, rsp_heading,
                        rsp_heading_valid);
               errors++;
            end
         end
      end
   end

   stim_row_type dir_rows[$];

   initial begin
      stim_row_type row;
      setpoint_type sp;
      m_radius = '0;
      {m_rate, m_cx, m_cy, m_cz, m_tx, m_ty, m_phase} = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset: zero orbit at the target, so close target with no heading
      dir_rows = '{
         '{OP_TICK, 20'd0, 1, '{32'd0, 32'd0, 32'd0, 16'd0, 1'b0}},
         '{OP_TICK, 20'd1000000, 1, '{32'd0, 32'd0, 32'd0, 16'd0, 1'b0}},
         '{OP_RESTART, 20'd1000000, 1, '{32'd0, 32'd0, 32'd0, 16'd0, 1'b0}},
         '{OP_TICK, 20'hFFFFF & 20'd1000000, 1, '{32'd0, 32'd0, 32'd0, 16'd0, 1'b0}}
      };
      foreach (dir_rows[k]) begin
         row = dir_rows[k];
         send_beat(row.op, row.dt);
         if (row.typed && row.op == OP_TICK) setpoints_due[$] = row.sp;
      end

      // extremes: largest radius and rates, centers at both ends
      load_orbit(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      for (int k = 0; k < 6; k++) send_beat(OP_TICK, k[0] ? 20'd1000000 : 20'd1);
      load_orbit(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      for (int k = 0; k < 5; k++) send_beat(OP_TICK, 20'd999999);
      send_beat(OP_RESTART, 20'd0);
      send_beat(OP_TICK, 20'd0);
      // quarter turns with the target on the circle and just off it
      load_orbit(32'h0001_0000, 32'h4000_0000, 32'd0, 32'd0, 32'hFFFF_0000,
                 32'h0001_0000, 32'd0);
      for (int k = 0; k < 5; k++) send_beat(OP_TICK, 20'd1);
      load_orbit(32'h0001_0000, 32'h4000_0000, 32'd0, 32'd0, 32'd0,
                 32'h0001_0000 + 32'd6553, 32'd0);
      send_beat(OP_TICK, 20'd0);
      send_beat(OP_TICK, 20'd4);

      tx_idle_pct = 35; rx_idle_pct = 63;
      for (int p = 0; p < 6; p++) begin
         load_random_orbit();
         random_beats(95);
      end
      tx_idle_pct = 63; rx_idle_pct = 35;
      for (int p = 0; p < 6; p++) begin
         load_random_orbit();
         random_beats(95);
      end
      tx_idle_pct = 0; rx_idle_pct = 0;
      for (int p = 0; p < 6; p++) begin
         load_random_orbit();
         // long receiver hold-off while the sender keeps offering beats
         if (p == 0) hold_req = 1;
         random_beats(95);
      end
      req_valid <= 1'b0;

      fork
         while (setpoints_due.size() != 0) @(posedge clock);
         repeat (200000) @(posedge clock);
      join_any
      disable fork;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (setpoints_due.size() != 0) begin
         $display("%0t %0d setpoints never arrived", $realtime, setpoints_due.size());
         errors++;
      end
      if (errors == 0) $display("[circle_orbit_setpoint_generator_unit] OK");
      else $display("[circle_orbit_setpoint_generator_unit] ERROR");
      $finish;
   end

endmodule

### sim.f
src/coso_pkg.sv
src/coso_cell.sv
src/coso_chain.sv
src/circle_orbit_setpoint_generator_unit.sv
src/coso_checker.sv
sim/tb_circle_orbit_setpoint_generator_unit.sv
